### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the expander RTL
// Clocked assertions, with or without a reset disable. Compiled out for
// synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge outside reset
`define DFSE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked at every clock edge, reset included
`define DFSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DFSE_ASSERT(lbl, clk, rst, prop, msg)
`define DFSE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/dfse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal format expander package
// Types, character codes and sizing constants shared by the expander.
// ----------------------------------------------------------------------------
package dfse_pkg;

   // Sizing
   localparam int CAP_W        = 13;
   localparam int POS_W        = 12;
   localparam int ARG_W        = 32;
   localparam logic [CAP_W-1:0] MAX_CAPACITY = 13'd4096;
   localparam logic [CAP_W-1:0] MIN_CAPACITY = 13'd2;

   // Command and result queues
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   // Decimal conversion: multiply by reciprocal of ten, then shift
   localparam int NUM_DIGITS   = 10;
   localparam int DIG_IDX_W    = $clog2(NUM_DIGITS);
   localparam logic [ARG_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT  = 35;
   localparam int QUO_W        = 2*ARG_W - RECIP_SHIFT;

   // Character codes
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_D       = 8'h64;
   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   // Register indexes
   localparam logic [2:0] CSR_ARG_A     = 3'd0;
   localparam logic [2:0] CSR_ARG_B     = 3'd1;
   localparam logic [2:0] CSR_ARG_C     = 3'd2;
   localparam logic [2:0] CSR_ARG_COUNT = 3'd3;
   localparam logic [2:0] CSR_CAPACITY  = 3'd4;

   // Character class decided at the front
   typedef enum logic [1:0] {
      CLS_PLAIN    = 2'd0,
      CLS_PERCENT  = 2'd1,
      CLS_LETTER_D = 2'd2
   } cls_type;

   // Parse mode of the back end
   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'b001,
      MODE_PERCENT = 3'b010,
      MODE_AFTER_D = 3'b100
   } mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       is_last;
      cls_type    cls;
   } cmd_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [7:0]       out_char;
      logic             end_of_run;
   } rsp_type;

   typedef struct packed {
      logic [ARG_W-1:0] arg_a;
      logic [ARG_W-1:0] arg_b;
      logic [ARG_W-1:0] arg_c;
      logic [1:0]       arg_count;
      logic [CAP_W-1:0] capacity;
   } cfg_type;

endpackage

### rtl/dfse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expander front end
// Accepts message items, tags each with its character class and holds them
// in a short command queue for the back end.
// ----------------------------------------------------------------------------
module dfse_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_ch,
   input  logic              req_has_char,
   input  logic              req_is_last,
   input  logic              req_push,
   output logic              req_full,
   output dfse_pkg::cmd_type cmd_head,
   output logic              cmd_valid,
   input  logic              cmd_pop
);
   import dfse_pkg::*;

   cmd_type                cmd_new;
   cmd_type                queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   // Classify the incoming character
   always_comb begin
      cmd_new.ch       = req_ch;
      cmd_new.has_char = req_has_char;
      cmd_new.is_last  = req_is_last;
      if (req_ch == CHAR_PERCENT) begin
         cmd_new.cls = CLS_PERCENT;
      end else if (req_ch == CHAR_D) begin
         cmd_new.cls = CLS_LETTER_D;
      end else begin
         cmd_new.cls = CLS_PLAIN;
      end
   end

   assign req_full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_head  = queue_ff[rd_ptr_ff];
   assign do_push   = req_push & ~req_full;
   assign do_pop    = cmd_pop & cmd_valid;

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(do_push);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(do_pop);
      count_in  = count_ff + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

### rtl/dfse_rspq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expander result queue
// Holds finished result items so the back end keeps working while the
// consumer stalls, until the queue is full.
// ----------------------------------------------------------------------------
module dfse_rspq (
   input  logic              clock,
   input  logic              reset,
   input  dfse_pkg::rsp_type wr_item,
   input  logic              wr_en,
   output logic              wr_full,
   output dfse_pkg::rsp_type rd_item,
   output logic              rd_empty,
   input  logic              rd_pop
);
   import dfse_pkg::*;

   rsp_type                queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign wr_full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign rd_empty = (count_ff == '0);
   assign rd_item  = queue_ff[rd_ptr_ff];
   assign do_push  = wr_en & ~wr_full;
   assign do_pop   = rd_pop & ~rd_empty;

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(do_push);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(do_pop);
      count_in  = count_ff + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

### rtl/dfse_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Expander back end
// Sequencer that tracks the parse mode and write position, converts arguments to
// decimal through a shared reciprocal-multiply digit unit and emits result items
// into the result queue, stalling while it is full; takes commands only when idle.
// ----------------------------------------------------------------------------
module dfse_back (
   input  logic              clock,
   input  logic              reset,
   input  dfse_pkg::cfg_type cfg,
   input  dfse_pkg::cmd_type cmd_head,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   output dfse_pkg::rsp_type out_item,
   output logic              out_push,
   input  logic              rspq_full
);
   import dfse_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b0_0000_0001,
      ST_PCT     = 9'b0_0000_0010,
      ST_CHAR    = 9'b0_0000_0100,
      ST_DIV_MUL = 9'b0_0000_1000,
      ST_DIV_REM = 9'b0_0001_0000,
      ST_SIGN    = 9'b0_0010_0000,
      ST_DIGIT   = 9'b0_0100_0000,
      ST_NL      = 9'b0_1000_0000,
      ST_NUL     = 9'b1_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [CAP_W-1:0]       wc_ff, wc_in;
   logic [1:0]             next_arg_ff, next_arg_in;
   cmd_type                cmd_ff, cmd_in;
   logic                   neg_ff, neg_in;
   logic [ARG_W-1:0]       mag_ff, mag_in;
   logic [2*ARG_W-1:0]     prod_ff, prod_in;
   logic [3:0]             digits_ff [NUM_DIGITS];
   logic [DIG_IDX_W-1:0]   nd_ff, nd_in;
   logic [DIG_IDX_W-1:0]   idx_ff, idx_in;

   logic [CAP_W-1:0]       cap;
   logic [CAP_W:0]         wc_plus1;
   logic                   wc_room;
   logic                   num_room;
   logic [1:0]             arg_cnt;
   logic [1:0]             arg_sel;
   logic [2:0]             arg_sel_p1;
   logic [ARG_W-1:0]       arg_raw;
   logic [QUO_W-1:0]       quo;
   logic [ARG_W-1:0]       quo_x10;
   logic [ARG_W-1:0]       rem_full;
   logic                   emit_req;
   logic [CAP_W-1:0]       emit_pos;
   logic [7:0]             emit_char;
   logic                   emit_eor;

   // Effective capacity and room checks
   always_comb begin
      if (cfg.capacity < MIN_CAPACITY) begin
         cap = MIN_CAPACITY;
      end else if (cfg.capacity > MAX_CAPACITY) begin
         cap = MAX_CAPACITY;
      end else begin
         cap = cfg.capacity;
      end
      wc_plus1 = {1'b0, wc_ff} + (CAP_W+1)'(1);
      wc_room  = (wc_ff < cap);
      num_room = (wc_plus1 < {1'b0, cap});
   end

   // Argument selection, cycling through the active count
   always_comb begin
      arg_cnt    = (cfg.arg_count == 2'd0) ? 2'd1 : cfg.arg_count;
      arg_sel    = (next_arg_ff < arg_cnt) ? next_arg_ff : 2'd0;
      arg_sel_p1 = {1'b0, arg_sel} + 3'd1;
      priority if (arg_sel == 2'd0) begin
         arg_raw = cfg.arg_a;
      end else if (arg_sel == 2'd1) begin
         arg_raw = cfg.arg_b;
      end else begin
         arg_raw = cfg.arg_c;
      end
   end

   // Digit unit: quotient from the registered product, remainder by subtract
   always_comb begin
      quo      = prod_ff[2*ARG_W-1:RECIP_SHIFT];
      quo_x10  = {quo, 3'b000} + {2'b00, quo, 1'b0};
      rem_full = mag_ff - quo_x10;
      prod_in  = 64'(mag_ff) * 64'(RECIP_10);
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      wc_in       = wc_ff;
      next_arg_in = next_arg_ff;
      cmd_in      = cmd_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      nd_in       = nd_ff;
      idx_in      = idx_ff;
      cmd_pop     = 1'b0;
      emit_req    = 1'b0;
      emit_pos    = wc_ff;
      emit_char   = cmd_ff.ch;
      emit_eor    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_head;
               state_in = cmd_head.is_last ? ST_NL : ST_IDLE;
               if (cmd_head.has_char && wc_room) begin
                  unique case (mode_ff)
                     MODE_PERCENT: begin
                        if (cmd_head.cls == CLS_LETTER_D) begin
                           mode_in     = MODE_AFTER_D;
                           neg_in      = arg_raw[ARG_W-1];
                           mag_in      = arg_raw[ARG_W-1] ? (ARG_W'(0) - arg_raw) : arg_raw;
                           next_arg_in = (arg_sel_p1 >= {1'b0, arg_cnt}) ? 2'd0
                                                                         : arg_sel_p1[1:0];
                           nd_in       = '0;
                           state_in    = ST_DIV_MUL;
                        end else begin
                           mode_in  = MODE_NORMAL;
                           state_in = ST_PCT;
                        end
                     end
                     MODE_AFTER_D: begin
                        mode_in  = MODE_NORMAL;
                        state_in = ST_CHAR;
                     end
                     default: begin
                        if (cmd_head.cls == CLS_PERCENT) begin
                           mode_in = MODE_PERCENT;
                        end else begin
                           state_in = ST_CHAR;
                        end
                     end
                  endcase
               end
            end
         end
         ST_PCT: begin
            emit_req  = 1'b1;
            emit_char = CHAR_PERCENT;
            if (!rspq_full) begin
               wc_in    = wc_plus1[CAP_W-1:0];
               state_in = ST_CHAR;
            end
         end
         ST_CHAR: begin
            // second character of a percent pair is dropped when full
            if (wc_room) begin
               emit_req = 1'b1;
               if (!rspq_full) begin
                  wc_in    = wc_plus1[CAP_W-1:0];
                  state_in = cmd_ff.is_last ? ST_NL : ST_IDLE;
               end
            end else begin
               state_in = cmd_ff.is_last ? ST_NL : ST_IDLE;
            end
         end
         ST_DIV_MUL: begin
            state_in = ST_DIV_REM;
         end
         ST_DIV_REM: begin
            mag_in = ARG_W'(quo);
            nd_in  = nd_ff + DIG_IDX_W'(1);
            if (quo == '0 || nd_ff == DIG_IDX_W'(NUM_DIGITS - 1)) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIV_MUL;
            end
         end
         ST_SIGN: begin
            idx_in = nd_ff - DIG_IDX_W'(1);
            if (neg_ff && num_room) begin
               emit_req  = 1'b1;
               emit_char = CHAR_MINUS;
               if (!rspq_full) begin
                  wc_in    = wc_plus1[CAP_W-1:0];
                  state_in = ST_DIGIT;
               end
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            // digits go out most significant first; one slot kept free
            emit_char = CHAR_ZERO + {4'b0000, digits_ff[idx_ff]};
            if (num_room) begin
               emit_req = 1'b1;
            end
            if (!num_room || !rspq_full) begin
               if (num_room) begin
                  wc_in = wc_plus1[CAP_W-1:0];
               end
               if (idx_ff == '0) begin
                  state_in = cmd_ff.is_last ? ST_NL : ST_IDLE;
               end else begin
                  idx_in = idx_ff - DIG_IDX_W'(1);
               end
            end
         end
         ST_NL: begin
            emit_req  = 1'b1;
            emit_char = CHAR_NL;
            emit_pos  = num_room ? wc_ff : (cap - CAP_W'(2));
            if (!rspq_full) begin
               state_in = ST_NUL;
            end
         end
         ST_NUL: begin
            emit_req  = 1'b1;
            emit_char = CHAR_NUL;
            emit_eor  = 1'b1;
            emit_pos  = num_room ? wc_plus1[CAP_W-1:0] : (cap - CAP_W'(1));
            if (!rspq_full) begin
               mode_in     = MODE_NORMAL;
               wc_in       = '0;
               next_arg_in = 2'd0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_push            = emit_req & ~rspq_full;
   assign out_item.position   = emit_pos[POS_W-1:0];
   assign out_item.out_char   = emit_char;
   assign out_item.end_of_run = emit_eor;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mode_ff     <= MODE_NORMAL;
         wc_ff       <= '0;
         next_arg_ff <= 2'd0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         wc_ff       <= wc_in;
         next_arg_ff <= next_arg_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
      nd_ff   <= nd_in;
      idx_ff  <= idx_in;
      if (state_ff == ST_DIV_REM) begin
         digits_ff[nd_ff] <= rem_full[3:0];
      end
   end

   // Checks
   `DFSE_ASSERT(a_digit_count, clock, reset, (state_ff == ST_DIV_REM) |-> (nd_ff < DIG_IDX_W'(NUM_DIGITS)), "digit buffer overrun")
   `DFSE_ASSERT(a_digit_value, clock, reset, (state_ff == ST_DIV_REM) |-> (rem_full < 32'd10), "digit unit remainder out of range")
   `DFSE_ASSERT(a_run_end, clock, reset, (out_push && out_item.end_of_run) |=> (wc_ff == '0 && mode_ff == MODE_NORMAL && state_ff == ST_IDLE), "state not cleared after terminator")
   `DFSE_ASSERT(a_nl_then_nul, clock, reset, (state_ff == ST_NL) |=> (state_ff == ST_NL || state_ff == ST_NUL), "newline not followed by terminator")

endmodule

### rtl/decimal_format_string_expander_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal format string expander
// Expands a message with %d substitutions into positioned output characters.
// ----------------------------------------------------------------------------
// Plain character: decoded in the idle state of the back-end sequencer and
//   emitted from the character state into the result queue.
// %d: decoded in the idle state, then a multiply and a remainder state per
//   decimal digit in the digit unit, a sign state and a digit state per digit slot.
// End of message adds a newline state and a terminator state.
// Synchronous reset clears both queues, the parse state and the configuration registers.
module decimal_format_string_expander_top (
   input  logic        clock,
   input  logic        reset,
   // message items
   input  logic [7:0]  req_ch,
   input  logic        req_has_char,
   input  logic        req_is_last,
   input  logic        push,
   output logic        full,
   // result items
   output logic [11:0] rsp_position,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_end_of_run,
   output logic        empty,
   input  logic        pop,
   // configuration
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import dfse_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd_head;
   logic    cmd_valid;
   logic    cmd_pop;
   rsp_type back_item;
   logic    back_push;
   logic    rspq_full;
   rsp_type rsp_item;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ARG_A:     cfg_in.arg_a     = csr_wdata;
            CSR_ARG_B:     cfg_in.arg_b     = csr_wdata;
            CSR_ARG_C:     cfg_in.arg_c     = csr_wdata;
            CSR_ARG_COUNT: cfg_in.arg_count = csr_wdata[1:0];
            CSR_CAPACITY:  cfg_in.capacity  = csr_wdata[CAP_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arg_a     <= '0;
         cfg_ff.arg_b     <= '0;
         cfg_ff.arg_c     <= '0;
         cfg_ff.arg_count <= 2'd3;
         cfg_ff.capacity  <= 13'd350;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end and command queue
   dfse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .req_has_char (req_has_char),
      .req_is_last  (req_is_last),
      .req_push     (push),
      .req_full     (full),
      .cmd_head     (cmd_head),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop)
   );

   // Back end sequencer and digit unit
   dfse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_head  (cmd_head),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .out_item  (back_item),
      .out_push  (back_push),
      .rspq_full (rspq_full)
   );

   // Result queue
   dfse_rspq u_rspq (
      .clock    (clock),
      .reset    (reset),
      .wr_item  (back_item),
      .wr_en    (back_push),
      .wr_full  (rspq_full),
      .rd_item  (rsp_item),
      .rd_empty (empty),
      .rd_pop   (pop)
   );

   assign rsp_position   = rsp_item.position;
   assign rsp_out_char   = rsp_item.out_char;
   assign rsp_end_of_run = rsp_item.end_of_run;

endmodule

### verif/tb_decimal_format_string_expander_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the decimal format string expander
// Feeds message characters, %d sequences, end markers and register updates,
// predicts every positioned output character and compares each popped
// result against the oldest prediction. Sender bursts and receiver stalls
// are random. A short table of directed steps runs first, then random
// messages under changing argument, count and capacity settings.
// ----------------------------------------------------------------------------
module tb_decimal_format_string_expander_top;
   import dfse_pkg::*;

   // DUT ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [7:0]  req_ch = '0;
   logic        req_has_char = 1'b0;
   logic        req_is_last = 1'b0;
   logic        push = 1'b0;
   logic        full;
   logic [11:0] rsp_position;
   logic [7:0]  rsp_out_char;
   logic        rsp_end_of_run;
   logic        empty;
   logic        pop = 1'b0;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   decimal_format_string_expander_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .req_has_char   (req_has_char),
      .req_is_last    (req_is_last),
      .push           (push),
      .full           (full),
      .rsp_position   (rsp_position),
      .rsp_out_char   (rsp_out_char),
      .rsp_end_of_run (rsp_end_of_run),
      .empty          (empty),
      .pop            (pop),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Drain wait after the last expected character
   localparam int SETTLE_CYCLES = 80;

   // One directed step: a register write or a message item
   typedef struct {
      bit           is_cfg;
      logic [2:0]   idx;
      logic [31:0]  data;
      logic [7:0]   ch;
      logic         has;
      logic         last;
      bit           typed;
      int           pos0;
      logic [127:0] txt;
      int           n;
   } step_row_type;

   step_row_type directed_steps[$];

   // Expected output characters, oldest first
   rsp_type expected_chars[$];
   // Characters caused by the item about to be sent
   rsp_type item_chars[$];

   int err_count = 0;
   int item_count = 0;
   int burst_left = 4;
   int stall_mode = 0;
   int mode_left = 0;

   // Predictor copy of registers and parse state
   logic [31:0] p_arg_a, p_arg_b, p_arg_c;
   logic [1:0]  p_count;
   logic [12:0] p_capacity;
   mode_type    pmode;
   int          wcount;
   int          narg;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      err_count++;
   endtask

   function automatic void emit_char(input int pos, input logic [7:0] c, input logic eor);
      rsp_type r;
      r.position   = pos[11:0];
      r.out_char   = c;
      r.end_of_run = eor;
      item_chars.push_back(r);
   endfunction

   // Signed decimal substitution of the next argument
   function automatic void expand_arg(input int cap);
      int          cnt;
      int          sel;
      int          nd;
      int          i;
      logic [31:0] raw;
      int unsigned mag;
      logic [3:0]  digs [10];
      cnt = (p_count == 2'd0) ? 1 : int'(p_count);
      sel = (narg < cnt) ? narg : 0;
      raw = (sel == 0) ? p_arg_a : ((sel == 1) ? p_arg_b : p_arg_c);
      mag = raw[31] ? (32'd0 - raw) : raw;
      narg = (sel + 1 >= cnt) ? 0 : sel + 1;
      nd = 0;
      do begin
         digs[nd] = 4'(mag % 10);
         mag = mag / 10;
         nd++;
      end while (mag != 0 && nd < 10);
      // sign and digits stop one short of capacity
      if (raw[31] && wcount < cap - 1) begin
         emit_char(wcount, CHAR_MINUS, 1'b0);
         wcount++;
      end
      for (i = nd - 1; i >= 0; i--) begin
         if (wcount < cap - 1) begin
            emit_char(wcount, CHAR_ZERO + 8'(digs[i]), 1'b0);
            wcount++;
         end
      end
   endfunction

   // Output characters caused by one message item
   function automatic void predict_item(input logic [7:0] ch, input logic has,
                                        input logic last);
      int cap;
      cap = int'(p_capacity);
      if (cap < 2) cap = 2;
      if (cap > int'(MAX_CAPACITY)) cap = int'(MAX_CAPACITY);
      item_chars.delete();
      if (has && wcount < cap) begin
         case (pmode)
            MODE_PERCENT: begin
               if (ch == CHAR_D) begin
                  pmode = MODE_AFTER_D;
                  expand_arg(cap);
               end else begin
                  emit_char(wcount, CHAR_PERCENT, 1'b0);
                  wcount++;
                  if (wcount < cap) begin
                     emit_char(wcount, ch, 1'b0);
                     wcount++;
                  end
                  pmode = MODE_NORMAL;
               end
            end
            MODE_AFTER_D: begin
               emit_char(wcount, ch, 1'b0);
               wcount++;
               pmode = MODE_NORMAL;
            end
            default: begin
               if (ch == CHAR_PERCENT) pmode = MODE_PERCENT;
               else begin
                  emit_char(wcount, ch, 1'b0);
                  wcount++;
               end
            end
         endcase
      end
      // end of message: newline and terminator, full buffer overwrites the tail
      if (last) begin
         if (wcount + 1 >= cap) begin
            emit_char(cap - 2, CHAR_NL, 1'b0);
            emit_char(cap - 1, CHAR_NUL, 1'b1);
         end else begin
            emit_char(wcount, CHAR_NL, 1'b0);
            emit_char(wcount + 1, CHAR_NUL, 1'b1);
         end
         pmode  = MODE_NORMAL;
         wcount = 0;
         narg   = 0;
      end
   endfunction

   // Register write, one cycle with enable high; called at a clock edge
   task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
      csr_index    <= idx;
      csr_wdata    <= data;
      csr_write_en <= 1'b1;
      @(posedge clock);
      case (idx)
         CSR_ARG_A:     p_arg_a = data;
         CSR_ARG_B:     p_arg_b = data;
         CSR_ARG_C:     p_arg_c = data;
         CSR_ARG_COUNT: p_count = data[1:0];
         CSR_CAPACITY:  p_capacity = data[12:0];
         default: ;
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending and wait until every expected character has come out
   task automatic drain();
      push <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Offer one item, queue its predicted characters once taken, then maybe gap
   task automatic send_item(input logic [7:0] ch, input logic has, input logic last);
      req_ch       <= ch;
      req_has_char <= has;
      req_is_last  <= last;
      push         <= 1'b1;
      do @(posedge clock); while (full);
      foreach (item_chars[k]) expected_chars.push_back(item_chars[k]);
      item_chars.delete();
      burst_left--;
      if (burst_left <= 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 6);
      end
   endtask

   task automatic send_predicted(input logic [7:0] ch, input logic has, input logic last);
      predict_item(ch, has, last);
      send_item(ch, has, last);
      item_count++;
   endtask

   // Directed table builders
   function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] data);
      step_row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.idx    = idx;
      r.data   = data;
      directed_steps.push_back(r);
   endfunction

   function automatic void add_typed(input logic [7:0] ch, input logic has, input logic last,
                                     input int pos0, input logic [127:0] txt, input int n);
      step_row_type r;
      r = '{default: '0};
      r.ch    = ch;
      r.has   = has;
      r.last  = last;
      r.typed = 1'b1;
      r.pos0  = pos0;
      r.txt   = txt;
      r.n     = n;
      directed_steps.push_back(r);
   endfunction

   function automatic void add_item(input logic [7:0] ch, input logic has, input logic last);
      step_row_type r;
      r = '{default: '0};
      r.ch   = ch;
      r.has  = has;
      r.last = last;
      directed_steps.push_back(r);
   endfunction

   function automatic logic [31:0] pick_arg();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'h8000_0000;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'hFFFF_FFFF;
         4:       return 32'($urandom_range(0, 1999)) - 32'd1000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [12:0] pick_capacity();
      case ($urandom_range(0, 9))
         0:       return 13'($urandom_range(0, 1));
         1:       return 13'd2;
         2:       return MAX_CAPACITY;
         3:       return 13'($urandom_range(4097, 8191));
         4:       return 13'd350;
         default: return 13'($urandom_range(3, 24));
      endcase
   endfunction

   // One random message: mostly well formed, with noise and broken pieces
   task automatic send_message();
      int          len;
      int          t;
      int          r;
      logic [7:0]  c;
      len = $urandom_range(1, 10);
      for (t = 0; t < len; t++) begin
         r = $urandom_range(0, 99);
         c = 8'($urandom);
         if (r < 35) send_predicted(c, 1'b1, 1'b0);
         else if (r < 60) begin
            send_predicted(CHAR_PERCENT, 1'b1, 1'b0);
            send_predicted(CHAR_D, 1'b1, 1'b0);
         end else if (r < 70) begin
            send_predicted(CHAR_PERCENT, 1'b1, 1'b0);
            send_predicted(c, 1'b1, 1'b0);
         end else if (r < 75) send_predicted(CHAR_NUL, 1'b1, 1'b0);
         else if (r < 80) send_predicted(8'hFF, 1'b1, 1'b0);
         else if (r < 88) send_predicted(c, 1'b0, 1'b0);
         else if (r < 92) begin
            // register update in the middle of a message, block idle
            drain();
            if ($urandom_range(0, 1) == 0)
               cfg_write(CSR_ARG_COUNT, {30'($urandom), 2'($urandom_range(0, 3))});
            else
               cfg_write(3'($urandom_range(0, 2)), pick_arg());
         end else send_predicted(CHAR_PERCENT, 1'b1, 1'b0);
      end
      // end of message on a character or on a bare end marker
      c = ($urandom_range(0, 4) == 0) ? CHAR_PERCENT : 8'($urandom);
      send_predicted(c, 1'($urandom_range(0, 3) != 0), 1'b1);
   endtask

   // Result side: check each popped character, stall on a pattern of its own
   always @(posedge clock) begin : result_check
      rsp_type e;
      if (reset) pop <= 1'b0;
      else begin
         if (pop && !empty) begin
            if (expected_chars.size() == 0)
               report_mismatch($sformatf("unexpected char pos %0d val %0h",
                                         rsp_position, rsp_out_char));
            else begin
               e = expected_chars.pop_front();
               if (rsp_position !== e.position)
                  report_mismatch($sformatf("position %0d, want %0d",
                                            rsp_position, e.position));
               if (rsp_out_char !== e.out_char)
                  report_mismatch($sformatf("char %0h at pos %0d, want %0h",
                                            rsp_out_char, e.position, e.out_char));
               if (rsp_end_of_run !== e.end_of_run)
                  report_mismatch($sformatf("end flag %0b at pos %0d, want %0b",
                                            rsp_end_of_run, e.position, e.end_of_run));
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(5, 60);
         end else mode_left--;
         case (stall_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= ($urandom_range(0, 7) == 0);
            default: pop <= 1'b0;
         endcase
      end
   end

   // Stimulus
   initial begin : stimulus
      step_row_type row;
      int           k;
      p_arg_a    = '0;
      p_arg_b    = '0;
      p_arg_c    = '0;
      p_count    = 2'd3;
      p_capacity = 13'd350;
      pmode      = MODE_NORMAL;
      wcount     = 0;
      narg       = 0;

      // reset settings: plain chars, zero argument, percent cases, end markers
      add_typed("A", 1'b1, 1'b0, 0, "A", 1);
      add_typed(CHAR_NUL, 1'b1, 1'b0, 1, 128'h00, 1);
      add_typed(8'hFF, 1'b1, 1'b0, 2, 128'hFF, 1);
      add_typed(CHAR_PERCENT, 1'b1, 1'b0, 0, 0, 0);
      add_typed(CHAR_D, 1'b1, 1'b0, 3, "0", 1);
      add_typed(CHAR_PERCENT, 1'b1, 1'b0, 4, "%", 1);
      add_typed(CHAR_PERCENT, 1'b1, 1'b0, 0, 0, 0);
      add_typed("q", 1'b1, 1'b0, 5, "%q", 2);
      add_typed("z", 1'b0, 1'b0, 0, 0, 0);
      add_typed(CHAR_PERCENT, 1'b1, 1'b0, 0, 0, 0);
      add_typed("z", 1'b0, 1'b1, 7, 0, 0);
      // extreme arguments, all three in turn
      add_cfg(CSR_ARG_A, 32'h8000_0000);
      add_cfg(CSR_ARG_B, 32'h7FFF_FFFF);
      add_cfg(CSR_ARG_C, 32'hFFFF_FFFF);
      add_cfg(CSR_ARG_COUNT, 32'd3);
      add_typed(CHAR_PERCENT, 1'b1, 1'b0, 0, 0, 0);
      add_typed(CHAR_D, 1'b1, 1'b0, 0, "-2147483648", 11);
      add_typed(",", 1'b1, 1'b0, 11, ",", 1);
      add_typed(CHAR_PERCENT, 1'b1, 1'b0, 0, 0, 0);
      add_typed(CHAR_D, 1'b1, 1'b0, 12, "2147483647", 10);
      add_typed(",", 1'b1, 1'b0, 22, ",", 1);
      add_typed(CHAR_PERCENT, 1'b1, 1'b0, 0, 0, 0);
      add_typed(CHAR_D, 1'b1, 1'b1, 23, "-1", 2);
      // tiny buffer: no room for the sign, then a dropped second char
      add_cfg(CSR_CAPACITY, 32'd3);
      add_typed("a", 1'b1, 1'b0, 0, "a", 1);
      add_typed("b", 1'b1, 1'b0, 1, "b", 1);
      add_typed(CHAR_PERCENT, 1'b1, 1'b0, 0, 0, 0);
      add_typed(CHAR_D, 1'b1, 1'b0, 0, 0, 0);
      add_item("e", 1'b1, 1'b1);
      add_typed("a", 1'b1, 1'b0, 0, "a", 1);
      add_typed("b", 1'b1, 1'b0, 1, "b", 1);
      add_typed(CHAR_PERCENT, 1'b1, 1'b0, 0, 0, 0);
      add_item("q", 1'b1, 1'b1);
      // capacity and count below range
      add_cfg(CSR_CAPACITY, 32'd0);
      add_cfg(CSR_ARG_COUNT, 32'd0);
      add_item("a", 1'b1, 1'b1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_steps[i]) begin
         row = directed_steps[i];
         if (row.is_cfg) begin
            drain();
            cfg_write(row.idx, row.data);
         end else begin
            predict_item(row.ch, row.has, row.last);
            if (row.typed) begin
               item_chars.delete();
               for (k = 0; k < row.n; k++)
                  emit_char(row.pos0 + k, row.txt[8*(row.n-1-k) +: 8], 1'b0);
               if (row.last) begin
                  emit_char(row.pos0 + row.n, CHAR_NL, 1'b0);
                  emit_char(row.pos0 + row.n + 1, CHAR_NUL, 1'b1);
               end
            end
            send_item(row.ch, row.has, row.last);
            item_count++;
         end
      end

      // random phases, each under fresh register settings
      while (item_count < 160) begin
         drain();
         cfg_write(CSR_ARG_A, pick_arg());
         cfg_write(CSR_ARG_B, pick_arg());
         cfg_write(CSR_ARG_C, pick_arg());
         cfg_write(CSR_ARG_COUNT, {30'($urandom), 2'($urandom_range(0, 3))});
         cfg_write(CSR_CAPACITY, {19'($urandom), pick_capacity()});
         repeat ($urandom_range(2, 4)) send_message();
      end

      drain();
      if (expected_chars.size() != 0)
         report_mismatch($sformatf("%0d chars never came out", expected_chars.size()));
      if (err_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/dfse_pkg.sv
rtl/dfse_front.sv
rtl/dfse_rspq.sv
rtl/dfse_back.sv
rtl/decimal_format_string_expander_top.sv
verif/tb_decimal_format_string_expander_top.sv
